FILE: rtl/pgcl_pkg.sv
package pgcl_pkg;

  // Console modes, as reported on the mode field.
  typedef enum logic [1:0] {
    MODE_PIN    = 2'd0,
    MODE_GATE   = 2'd1,
    MODE_SHELL  = 2'd2,
    MODE_LOCKED = 2'd3
  } mode_t;

  // Event codes, as reported on the event_res field.
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_GRANTED   = 3'd1,
    EV_BAD_PIN   = 3'd2,
    EV_LOCKED    = 3'd3,
    EV_SHELL     = 3'd4,
    EV_BAD_WORD  = 3'd5,
    EV_SHELL_END = 3'd6
  } event_t;

  // Operation classes decided by the front end.
  typedef enum logic [1:0] {
    OP_LEAVE     = 2'd0,
    OP_NEWLINE   = 2'd1,
    OP_BACKSPACE = 2'd2,
    OP_CHAR      = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] key;
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_PIN_VALUE  = 2'd0;
  localparam logic [1:0] REG_PIN_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_FAILS  = 2'd2;

  // Register reset values.
  localparam logic [63:0] PIN_VALUE_RST  = 64'd825307441;
  localparam logic [3:0]  PIN_LENGTH_RST = 4'd4;
  localparam logic [3:0]  MAX_FAILS_RST  = 4'd5;

  // Key bytes.
  localparam logic [7:0] KEY_NEWLINE   = 8'd10;
  localparam logic [7:0] KEY_BACKSPACE = 8'd8;
  localparam logic [7:0] KEY_STAR      = 8'd42;

  // Gate word "shell".
  localparam int GATE_LEN = 5;
  localparam logic [7:0] GATE_WORD [GATE_LEN] = '{8'h73, 8'h68, 8'h65, 8'h6c, 8'h6c};

  // Width of short lengths (PIN length, compare length).
  localparam int LEN_W = 4;
  localparam logic [3:0] FAIL_SAT = 4'd15;

endpackage

FILE: rtl/pgcl_if.sv
interface pgcl_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] key_char;
  modport source (output valid, func, key_char, input ready);
  modport sink (input valid, func, key_char, output ready);
endinterface

interface pgcl_out_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_char;
  logic       shell_key_valid;
  logic [7:0] shell_key;
  logic [2:0] event_res;
  logic [3:0] fail_count;
  logic [1:0] mode;
  modport source (output valid, echo_valid, echo_char, shell_key_valid, shell_key,
                  event_res, fail_count, mode, input ready);
  modport sink (input valid, echo_valid, echo_char, shell_key_valid, shell_key,
                event_res, fail_count, mode, output ready);
endinterface

interface pgcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/pgcl_front.sv
module pgcl_front
  import pgcl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  pgcl_in_if.sink   key_in,
  output op_t       op,
  output logic      op_valid,
  input  logic      op_ready
);

  op_t  op_reg;
  logic valid_reg;
  op_t  op_next;

  // Classify the incoming word by its function flag and key byte.
  always_comb begin
    op_next.key = key_in.key_char;
    if (key_in.func) begin
      op_next.kind = OP_LEAVE;
    end else if (key_in.key_char == KEY_NEWLINE) begin
      op_next.kind = OP_NEWLINE;
    end else if (key_in.key_char == KEY_BACKSPACE) begin
      op_next.kind = OP_BACKSPACE;
    end else begin
      op_next.kind = OP_CHAR;
    end
  end

  assign key_in.ready = !valid_reg || op_ready;

  // Decoded word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_reg <= 1'b0;
    end else if (key_in.ready) begin
      valid_reg <= key_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_in.valid && key_in.ready) begin
      op_reg <= op_next;
    end
  end

  assign op       = op_reg;
  assign op_valid = valid_reg;

endmodule

FILE: rtl/pgcl_queue.sv
module pgcl_queue
  import pgcl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  op_t  push_op,
  input  logic push_valid,
  output logic push_ready,
  output op_t  pop_op,
  output logic pop_valid,
  input  logic pop_ready
);

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_op     = slots[rd_ptr];

  // Pointers and fill count of the two-entry queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

FILE: rtl/pgcl_back.sv
module pgcl_back
  import pgcl_pkg::*;
#(
  parameter int LINE_DEPTH = 64,
  parameter int PIN_CHARS  = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  op_t        op,
  input  logic       op_valid,
  output logic       op_ready,
  pgcl_cfg_if.sink   cfg,
  pgcl_out_if.source res
);

  localparam int LW   = $clog2(LINE_DEPTH);
  localparam int KEEP = ((PIN_CHARS > GATE_LEN) ? PIN_CHARS : GATE_LEN) + 1;
  localparam int CW   = ((LW > LEN_W) ? LW : LEN_W) + 1;
  localparam logic [LW-1:0] LINE_MAX = LW'(LINE_DEPTH - 1);
  localparam logic [LEN_W-1:0] PIN_SAT = LEN_W'(PIN_CHARS);
  localparam logic [LEN_W-1:0] GATE_TL = LEN_W'(GATE_LEN);

  // Configuration registers.
  logic [63:0]      pin_value;
  logic [LEN_W-1:0] pin_length;
  logic [3:0]       max_fails;

  // Console state. Only the head of the line is kept: the compare never
  // looks past the longest target plus its terminator.
  mode_t            mode;
  mode_t            mode_next;
  logic [LW-1:0]    len;
  logic [LW-1:0]    len_next;
  logic [3:0]       wrong;
  logic [3:0]       wrong_next;
  logic [7:0]       line_head [KEEP];
  logic             store_key;

  // Result register.
  logic             out_valid;
  logic             echo_valid_next;
  logic [7:0]       echo_char_next;
  logic             shell_valid_next;
  logic [7:0]       shell_key_next;
  event_t           event_next;
  logic             echo_valid_reg;
  logic [7:0]       echo_char_reg;
  logic             shell_valid_reg;
  logic [7:0]       shell_key_reg;
  event_t           event_reg;
  logic [3:0]       fail_reg;
  mode_t            mode_reg;

  logic             pop;
  logic [7:0]       pin_tgt [KEEP];
  logic [LEN_W-1:0] pin_n;
  logic [LEN_W-1:0] pin_tl;
  logic             pin_ok;
  logic             gate_ok;
  logic [3:0]       wrong_inc;

  assign cfg.ready = 1'b1;
  assign op_ready  = !out_valid || res.ready;
  assign pop       = op_valid && op_ready;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_value  <= PIN_VALUE_RST;
      pin_length <= PIN_LENGTH_RST;
      max_fails  <= MAX_FAILS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PIN_VALUE:  pin_value  <= cfg.data;
        REG_PIN_LENGTH: pin_length <= cfg.data[LEN_W-1:0];
        REG_MAX_FAILS:  max_fails  <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // PIN bytes and the PIN's string length (saturated, cut at a zero byte).
  always_comb begin
    pin_n  = (pin_length > PIN_SAT) ? PIN_SAT : pin_length;
    pin_tl = pin_n;
    for (int i = KEEP - 1; i >= 0; i--) begin
      if (i < PIN_CHARS) begin
        pin_tgt[i] = pin_value[8*(i%8) +: 8];
        if ((LEN_W'(i) < pin_n) && (pin_value[8*(i%8) +: 8] == 8'd0)) begin
          pin_tl = LEN_W'(i);
        end
      end else begin
        pin_tgt[i] = 8'd0;
      end
    end
  end

  // String compares of the line head against the PIN and the gate word.
  always_comb begin
    pin_ok  = 1'b1;
    gate_ok = 1'b1;
    for (int i = 0; i < KEEP; i++) begin
      if (LEN_W'(i) < pin_tl) begin
        pin_ok = pin_ok && (CW'(i) < CW'(len)) && (line_head[i] == pin_tgt[i]);
      end
      if (LEN_W'(i) == pin_tl) begin
        pin_ok = pin_ok && ((CW'(len) == CW'(pin_tl)) || (line_head[i] == 8'd0));
      end
      if (i < GATE_LEN) begin
        gate_ok = gate_ok && (CW'(i) < CW'(len)) && (line_head[i] == GATE_WORD[i % GATE_LEN]);
      end
      if (LEN_W'(i) == GATE_TL) begin
        gate_ok = gate_ok && ((CW'(len) == CW'(GATE_TL)) || (line_head[i] == 8'd0));
      end
    end
  end

  assign wrong_inc = (wrong < FAIL_SAT) ? wrong + 4'd1 : wrong;

  // Next state.
  always_comb begin
    mode_next  = mode;
    len_next   = len;
    wrong_next = wrong;
    store_key  = 1'b0;
    case (op.kind)
      OP_LEAVE: begin
        if (mode == MODE_SHELL) begin
          mode_next = MODE_GATE;
        end
      end
      OP_NEWLINE: begin
        if (mode == MODE_PIN || mode == MODE_GATE) begin
          len_next = '0;
          if (mode == MODE_PIN) begin
            if (pin_ok) begin
              mode_next = MODE_GATE;
            end else begin
              wrong_next = wrong_inc;
              if (wrong_inc >= max_fails) begin
                mode_next = MODE_LOCKED;
              end
            end
          end else if (gate_ok) begin
            mode_next = MODE_SHELL;
          end
        end
      end
      OP_BACKSPACE: begin
        if ((mode == MODE_PIN || mode == MODE_GATE) && len != '0) begin
          len_next = len - LW'(1);
        end
      end
      OP_CHAR: begin
        if ((mode == MODE_PIN || mode == MODE_GATE) && len < LINE_MAX) begin
          len_next  = len + LW'(1);
          store_key = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result fields.
  always_comb begin
    echo_valid_next  = 1'b0;
    echo_char_next   = 8'd0;
    shell_valid_next = 1'b0;
    shell_key_next   = 8'd0;
    event_next       = EV_NONE;
    if (op.kind == OP_LEAVE) begin
      if (mode == MODE_SHELL) begin
        event_next = EV_SHELL_END;
      end
    end else if (mode == MODE_SHELL) begin
      shell_valid_next = 1'b1;
      shell_key_next   = op.key;
    end else if (mode != MODE_LOCKED) begin
      case (op.kind)
        OP_NEWLINE: begin
          echo_valid_next = 1'b1;
          echo_char_next  = KEY_NEWLINE;
          if (mode == MODE_PIN) begin
            if (pin_ok) begin
              event_next = EV_GRANTED;
            end else if (wrong_inc >= max_fails) begin
              event_next = EV_LOCKED;
            end else begin
              event_next = EV_BAD_PIN;
            end
          end else begin
            event_next = gate_ok ? EV_SHELL : EV_BAD_WORD;
          end
        end
        OP_BACKSPACE: begin
          if (len != '0) begin
            echo_valid_next = 1'b1;
            echo_char_next  = KEY_BACKSPACE;
          end
        end
        OP_CHAR: begin
          if (len < LINE_MAX) begin
            echo_valid_next = 1'b1;
            echo_char_next  = (mode == MODE_PIN) ? KEY_STAR : op.key;
          end
        end
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_PIN;
      len   <= '0;
      wrong <= 4'd0;
    end else if (pop) begin
      mode  <= mode_next;
      len   <= len_next;
      wrong <= wrong_next;
    end
  end

  // Line head storage; characters beyond it are counted only.
  always_ff @(posedge clk) begin
    for (int i = 0; i < KEEP; i++) begin
      if (pop && store_key && (CW'(len) == CW'(i))) begin
        line_head[i] <= op.key;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op_ready) begin
      out_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      echo_valid_reg  <= echo_valid_next;
      echo_char_reg   <= echo_char_next;
      shell_valid_reg <= shell_valid_next;
      shell_key_reg   <= shell_key_next;
      event_reg       <= event_next;
      fail_reg        <= wrong_next;
      mode_reg        <= mode_next;
    end
  end

  assign res.valid           = out_valid;
  assign res.echo_valid      = echo_valid_reg;
  assign res.echo_char       = echo_char_reg;
  assign res.shell_key_valid = shell_valid_reg;
  assign res.shell_key       = shell_key_reg;
  assign res.event_res       = event_reg;
  assign res.fail_count      = fail_reg;
  assign res.mode            = mode_reg;

`ifndef SYNTH
  // Once locked, the console stays locked until reset.
  a_lock_holds: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_LOCKED |=> mode == MODE_LOCKED)
    else $error("locked mode was left without reset");

  // A reported lockout always comes with the locked mode.
  a_lock_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_reg == EV_LOCKED |-> mode_reg == MODE_LOCKED)
    else $error("lock event without locked mode");

  // The fail count moves only when a word is taken from the queue.
  a_fail_stable: assert property (@(posedge clk) disable iff (rst)
    !pop |=> $stable(wrong))
    else $error("fail count changed without a word");

  // A grant leaves the console in gate word mode.
  a_grant_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_reg == EV_GRANTED |-> mode_reg == MODE_GATE)
    else $error("grant without gate word mode");
`endif

endmodule

FILE: rtl/pin_gate_console_lock_core.sv
// A key word passes through the decode register, a queue slot and the result
// register, in that order. Throughput: one key word per cycle while res.ready
// is held high; every key word yields one result word.
// Reset (rst, synchronous): PIN entry mode, empty line, fail count zero, empty
// queue, configuration registers at their defaults; no clearing pass.
module pin_gate_console_lock_core
  import pgcl_pkg::*;
#(
  parameter int LINE_DEPTH = 64,
  parameter int PIN_CHARS  = 8
) (
  input  logic       clk,
  input  logic       rst,
  pgcl_in_if.sink    key_in,
  pgcl_cfg_if.sink   cfg,
  pgcl_out_if.source res
);

  op_t  front_op;
  logic front_valid;
  logic front_ready;
  op_t  back_op;
  logic back_valid;
  logic back_ready;

  // Front end: decode each key word.
  pgcl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .key_in   (key_in),
    .op       (front_op),
    .op_valid (front_valid),
    .op_ready (front_ready)
  );

  // Decoupling queue.
  pgcl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_op    (front_op),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_op     (back_op),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // Back end: console state and results.
  pgcl_back #(
    .LINE_DEPTH (LINE_DEPTH),
    .PIN_CHARS  (PIN_CHARS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (back_op),
    .op_valid (back_valid),
    .op_ready (back_ready),
    .cfg      (cfg),
    .res      (res)
  );

endmodule

FILE: verif/pin_gate_console_lock_core_tb.sv
`timescale 1ns / 1ps

module pin_gate_console_lock_core_tb;
  import pgcl_pkg::*;

  localparam int LINE_SLOTS   = 64;
  localparam int PIN_SLOTS    = 8;
  localparam int TOTAL_KEYS   = 1600;
  localparam int MAX_WAIT     = 17;
  localparam int FAIL_CEILING = 15;
  // Wrong PINs spent before the grant; stays below every fail limit in use.
  localparam int WRONG_BUDGET = 12;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [1:0] REG_SPARE  = 2'd3;
  localparam logic       FUNC_KEY   = 1'b0;
  localparam logic       FUNC_LEAVE = 1'b1;
  localparam logic [7:0] KEY_ZERO   = 8'h00;
  localparam logic [7:0] KEY_DIGIT0 = 8'h30;

  typedef struct {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       shell_key_valid;
    logic [7:0] shell_key;
    event_t     ev;
    logic [3:0] fails;
    mode_t      mode;
  } console_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pgcl_in_if  key_in ();
  pgcl_cfg_if cfg ();
  pgcl_out_if res ();

  pin_gate_console_lock_core #(
    .LINE_DEPTH(LINE_SLOTS),
    .PIN_CHARS (PIN_SLOTS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .key_in(key_in),
    .cfg   (cfg),
    .res   (res)
  );

  always #5 clk = ~clk;

  // Shadow copy of the console state and of its registers.
  mode_t       shadow_mode;
  logic [7:0]  typed_line [LINE_SLOTS];
  int          line_len;
  int          wrong_count;
  logic [63:0] pin_word;
  int          pin_len;
  int          fail_limit;

  console_word_t awaited_words [$];
  int errors     = 0;
  int keys_sent  = 0;
  bit sender_calm = 1'b0;
  bit sink_calm   = 1'b0;
  bit took_result = 1'b0;
  int sink_hold   = 0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Length of the edit line as a C string.
  function automatic int line_text_len();
    int n;
    n = 0;
    while (n < line_len && typed_line[n] != KEY_ZERO) n++;
    return n;
  endfunction

  // Compares the edit line with the first n bytes of txt, cut at a zero byte.
  function automatic bit line_equals(input logic [7:0] txt [PIN_SLOTS], input int n);
    int i;
    int tl;
    tl = n;
    for (i = 0; i < n; i++) begin
      if (txt[i] == KEY_ZERO) begin
        tl = i;
        break;
      end
    end
    if (line_text_len() != tl) return 1'b0;
    for (i = 0; i < tl; i++) begin
      if (typed_line[i] != txt[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit pin_accepted();
    logic [7:0] txt [PIN_SLOTS];
    int i;
    int n;
    n = (pin_len > PIN_SLOTS) ? PIN_SLOTS : pin_len;
    for (i = 0; i < PIN_SLOTS; i++) txt[i] = pin_word[8*i +: 8];
    return line_equals(txt, n);
  endfunction

  function automatic bit gate_word_typed();
    logic [7:0] txt [PIN_SLOTS];
    string gw;
    int i;
    gw = "shell";
    for (i = 0; i < PIN_SLOTS; i++) txt[i] = (i < gw.len()) ? gw[i] : KEY_ZERO;
    return line_equals(txt, gw.len());
  endfunction

  // Advances the shadow state by one key word and returns the screen word it yields.
  function automatic console_word_t console_predict(input logic f, input logic [7:0] k);
    console_word_t w;
    w.echo_valid      = 1'b0;
    w.echo_char       = 8'd0;
    w.shell_key_valid = 1'b0;
    w.shell_key       = 8'd0;
    w.ev              = EV_NONE;
    if (f == FUNC_LEAVE) begin
      if (shadow_mode == MODE_SHELL) begin
        shadow_mode = MODE_GATE;
        w.ev = EV_SHELL_END;
      end
    end else if (shadow_mode == MODE_SHELL) begin
      w.shell_key_valid = 1'b1;
      w.shell_key       = k;
    end else if (shadow_mode != MODE_LOCKED) begin
      if (k == KEY_NEWLINE) begin
        w.echo_valid = 1'b1;
        w.echo_char  = KEY_NEWLINE;
        if (shadow_mode == MODE_PIN) begin
          if (pin_accepted()) begin
            shadow_mode = MODE_GATE;
            w.ev = EV_GRANTED;
          end else begin
            if (wrong_count < FAIL_CEILING) wrong_count++;
            if (wrong_count >= fail_limit) begin
              shadow_mode = MODE_LOCKED;
              w.ev = EV_LOCKED;
            end else begin
              w.ev = EV_BAD_PIN;
            end
          end
        end else if (gate_word_typed()) begin
          shadow_mode = MODE_SHELL;
          w.ev = EV_SHELL;
        end else begin
          w.ev = EV_BAD_WORD;
        end
        line_len = 0;
      end else if (k == KEY_BACKSPACE) begin
        if (line_len > 0) begin
          line_len--;
          w.echo_valid = 1'b1;
          w.echo_char  = KEY_BACKSPACE;
        end
      end else if (line_len < LINE_SLOTS - 1) begin
        typed_line[line_len] = k;
        line_len++;
        w.echo_valid = 1'b1;
        w.echo_char  = (shadow_mode == MODE_PIN) ? KEY_STAR : k;
      end
    end
    w.fails = wrong_count[3:0];
    w.mode  = shadow_mode;
    return w;
  endfunction

  // Keeps a PIN-mode newline from granting or locking before the grant test.
  function automatic logic [7:0] pin_safe_key(input logic [7:0] k);
    if (shadow_mode == MODE_PIN && k == KEY_NEWLINE &&
        (pin_accepted() || wrong_count >= WRONG_BUDGET)) begin
      return KEY_BACKSPACE;
    end
    return k;
  endfunction

  // Random PIN-mode key, often the next PIN character to make near misses.
  function automatic logic [7:0] pin_random_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return KEY_NEWLINE;
    if (pick < 20) return KEY_BACKSPACE;
    if (pick < 28) return KEY_ZERO;
    if (pick < 48 && line_len < PIN_SLOTS) return pin_word[8*line_len +: 8];
    if (pick < 75) return KEY_DIGIT0 + 8'($urandom_range(0, 9));
    return 8'($urandom_range(0, 255));
  endfunction

  // Drives one key word; called and returning at a falling edge.
  task automatic send_key(input logic f, input logic [7:0] k);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      key_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    key_in.valid    <= 1'b1;
    key_in.func     <= f;
    key_in.key_char <= k;
    @(posedge clk);
    while (!key_in.ready) @(posedge clk);
    if (!(f == FUNC_LEAVE && shadow_mode != MODE_SHELL)) keys_sent++;
    awaited_words.push_back(console_predict(f, k));
    @(negedge clk);
  endtask

  // Holds off new key words until every screen word has come back.
  task automatic wait_idle();
    key_in.valid <= 1'b0;
    do @(negedge clk); while (awaited_words.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_PIN_VALUE:  pin_word = val;
      REG_PIN_LENGTH: pin_len = val[3:0];
      REG_MAX_FAILS:  fail_limit = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Receiver stalls: a fresh hold is drawn after every screen word taken.
  always @(negedge clk) begin
    if (took_result) begin
      took_result = 1'b0;
      sink_hold = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (sink_hold > 0) begin
      res.ready <= 1'b0;
      sink_hold--;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // Every screen word is checked against the oldest prediction.
  always @(posedge clk) begin
    console_word_t want;
    if (!rst && res.valid && res.ready) begin
      took_result = 1'b1;
      if (awaited_words.size() == 0) begin
        errors++;
        $display("%0t: screen word with none expected: expected nothing, actual echo %0d/%0d",
                 $time, res.echo_valid, res.echo_char);
      end else begin
        want = awaited_words.pop_front();
        check_field("echo_valid", want.echo_valid, res.echo_valid);
        check_field("echo_char", want.echo_char, res.echo_char);
        check_field("shell_key_valid", want.shell_key_valid, res.shell_key_valid);
        check_field("shell_key", want.shell_key, res.shell_key);
        check_field("event_res", want.ev, res.event_res);
        check_field("fail_count", want.fails, res.fail_count);
        check_field("mode", want.mode, res.mode);
      end
    end
  end

  // Switches idling on and off so that long stretches run at full rate.
  initial begin
    forever begin
      repeat ($urandom_range(40, 400)) @(posedge clk);
      sender_calm = ($urandom_range(0, 3) == 0);
      sink_calm   = ($urandom_range(0, 3) == 0);
    end
  end

  // Edits and wrong PINs at the default registers, then with a higher fail limit.
  task automatic test_pin_directed();
    send_key(FUNC_LEAVE, 8'hFF);
    send_key(FUNC_KEY, KEY_BACKSPACE);
    send_key(FUNC_KEY, KEY_DIGIT0 + 8'd1);
    send_key(FUNC_KEY, KEY_DIGIT0 + 8'd1);
    send_key(FUNC_KEY, KEY_DIGIT0 + 8'd1);
    send_key(FUNC_KEY, 8'hFF);
    send_key(FUNC_KEY, KEY_NEWLINE);
    send_key(FUNC_KEY, KEY_NEWLINE);
    write_reg(REG_MAX_FAILS, 64'd15);
    repeat (5) send_key(FUNC_KEY, KEY_DIGIT0 + 8'd1);
    send_key(FUNC_KEY, KEY_NEWLINE);
    // A zero byte cuts the line short of the PIN.
    send_key(FUNC_KEY, KEY_DIGIT0 + 8'd1);
    send_key(FUNC_KEY, KEY_ZERO);
    send_key(FUNC_KEY, KEY_DIGIT0 + 8'd1);
    send_key(FUNC_KEY, 8'h80);
    send_key(FUNC_KEY, KEY_BACKSPACE);
    send_key(FUNC_KEY, KEY_NEWLINE);
  endtask

  // Random PIN entry under several PIN settings, never granting or locking.
  task automatic test_pin_settings();
    int s;
    for (s = 0; s < 6; s++) begin
      case (s)
        0: begin
          write_reg(REG_PIN_LENGTH, 64'd15);
          write_reg(REG_PIN_VALUE, rand64());
        end
        1: write_reg(REG_PIN_LENGTH, 64'd0);
        2: begin
          write_reg(REG_PIN_LENGTH, 64'd1);
          write_reg(REG_PIN_VALUE, 64'd0);
        end
        3: begin
          write_reg(REG_PIN_LENGTH, 64'd8);
          write_reg(REG_PIN_VALUE, {64{1'b1}});
        end
        4: begin
          write_reg(REG_PIN_LENGTH, 64'd9);
          write_reg(REG_PIN_VALUE, rand64() & ~(64'hFF << 24));
        end
        default: begin
          write_reg(REG_SPARE, rand64());
          write_reg(REG_PIN_LENGTH, 64'd4);
          write_reg(REG_PIN_VALUE, rand64() | 64'h0101_0101_0101_0101);
        end
      endcase
      repeat (45) begin
        if ($urandom_range(0, 99) < 3) send_key(FUNC_LEAVE, 8'($urandom_range(0, 255)));
        else send_key(FUNC_KEY, pin_safe_key(pin_random_key()));
      end
    end
  endtask

  // Grant with a PIN that saturates in length and ends early at a zero byte.
  task automatic test_pin_grant();
    while (line_len > 0) send_key(FUNC_KEY, KEY_BACKSPACE);
    write_reg(REG_PIN_LENGTH, 64'd12);
    write_reg(REG_PIN_VALUE, 64'h3535_0039_80FF_3337);
    send_key(FUNC_KEY, 8'h37);
    send_key(FUNC_KEY, 8'h33);
    send_key(FUNC_KEY, 8'h78);
    send_key(FUNC_KEY, KEY_BACKSPACE);
    send_key(FUNC_KEY, 8'hFF);
    send_key(FUNC_KEY, 8'h80);
    send_key(FUNC_KEY, 8'h39);
    send_key(FUNC_KEY, KEY_ZERO);
    send_key(FUNC_KEY, 8'h71);
    send_key(FUNC_KEY, KEY_NEWLINE);
  endtask

  // Gate word and shell pass-through, edge cases first.
  task automatic test_gate_shell_directed();
    send_key(FUNC_LEAVE, 8'h78);
    send_key(FUNC_KEY, 8'h73);
    send_key(FUNC_KEY, 8'h68);
    send_key(FUNC_KEY, 8'h65);
    send_key(FUNC_KEY, 8'h6c);
    send_key(FUNC_KEY, 8'h6c);
    send_key(FUNC_KEY, 8'h6c);
    send_key(FUNC_KEY, KEY_BACKSPACE);
    send_key(FUNC_KEY, KEY_ZERO);
    send_key(FUNC_KEY, 8'h7a);
    send_key(FUNC_KEY, KEY_NEWLINE);
    send_key(FUNC_KEY, KEY_NEWLINE);
    send_key(FUNC_KEY, KEY_BACKSPACE);
    send_key(FUNC_KEY, KEY_ZERO);
    send_key(FUNC_KEY, 8'hFF);
    send_key(FUNC_LEAVE, KEY_NEWLINE);
    send_key(FUNC_LEAVE, 8'h00);
    send_key(FUNC_KEY, KEY_NEWLINE);
  endtask

  // Types the gate word with random slips, fixes and trailing junk.
  task automatic type_gate_word();
    string gw;
    int i;
    logic [7:0] c;
    gw = "shell";
    for (i = 0; i < gw.len(); i++) begin
      c = gw[i];
      if ($urandom_range(0, 99) < 15) begin
        send_key(FUNC_KEY, 8'($urandom_range(0, 255)) | 8'h10);
        send_key(FUNC_KEY, KEY_BACKSPACE);
      end
      if ($urandom_range(0, 99) < 4) c = c ^ 8'h20;
      send_key(FUNC_KEY, c);
    end
    if ($urandom_range(0, 99) < 10) begin
      send_key(FUNC_KEY, KEY_ZERO);
      send_key(FUNC_KEY, 8'($urandom_range(0, 255)) | 8'h10);
    end
    send_key(FUNC_KEY, KEY_NEWLINE);
  endtask

  task automatic test_gate_shell_random();
    int phase;
    int next_retune;
    int pick;
    int n;
    logic [7:0] k;
    phase = 0;
    next_retune = keys_sent;
    while (keys_sent < TOTAL_KEYS) begin
      // Register changes between phases; they must not disturb gate or shell mode.
      if (keys_sent >= next_retune) begin
        case (phase)
          0: begin
            write_reg(REG_MAX_FAILS, 64'd0);
            write_reg(REG_PIN_LENGTH, 64'd15);
            write_reg(REG_PIN_VALUE, 64'd0);
          end
          1: begin
            write_reg(REG_MAX_FAILS, 64'd1);
            write_reg(REG_PIN_LENGTH, 64'd0);
            write_reg(REG_PIN_VALUE, {64{1'b1}});
          end
          2: begin
            write_reg(REG_MAX_FAILS, 64'd15);
            write_reg(REG_PIN_LENGTH, 64'd8);
            write_reg(REG_PIN_VALUE, rand64());
          end
          default: begin
            write_reg(REG_MAX_FAILS, 64'($urandom_range(0, 15)));
            write_reg(REG_PIN_LENGTH, 64'($urandom_range(0, 15)));
            write_reg(REG_PIN_VALUE, rand64());
          end
        endcase
        phase++;
        next_retune = keys_sent + 300;
      end
      pick = $urandom_range(0, 99);
      if (shadow_mode == MODE_SHELL) begin
        n = $urandom_range(1, 12);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) send_key(FUNC_KEY, KEY_NEWLINE);
          else send_key(FUNC_KEY, 8'($urandom_range(0, 255)));
        end
        if (pick < 85) send_key(FUNC_LEAVE, 8'($urandom_range(0, 255)));
      end else if (pick < 55) begin
        type_gate_word();
      end else if (pick < 85) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          case ($urandom_range(0, 7))
            0: send_key(FUNC_KEY, KEY_NEWLINE);
            1: send_key(FUNC_KEY, KEY_BACKSPACE);
            2: send_key(FUNC_KEY, KEY_ZERO);
            3: send_key(FUNC_LEAVE, 8'($urandom_range(0, 255)));
            default: send_key(FUNC_KEY, 8'($urandom_range(0, 255)));
          endcase
        end
      end else if (pick < 93) begin
        // Long line past the end of the store; the surplus is dropped silently.
        n = $urandom_range(55, 75);
        repeat (n) begin
          k = 8'($urandom_range(0, 255));
          if (k == KEY_NEWLINE || k == KEY_BACKSPACE) k = 8'h41;
          send_key(FUNC_KEY, k);
        end
        if ($urandom_range(0, 1) == 0) send_key(FUNC_KEY, KEY_BACKSPACE);
        send_key(FUNC_KEY, KEY_NEWLINE);
      end else begin
        send_key(FUNC_LEAVE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int i;
    key_in.valid    = 1'b0;
    key_in.func     = FUNC_KEY;
    key_in.key_char = 8'd0;
    cfg.valid       = 1'b0;
    cfg.index       = REG_PIN_VALUE;
    cfg.data        = 64'd0;
    res.ready       = 1'b0;
    shadow_mode     = MODE_PIN;
    for (i = 0; i < LINE_SLOTS; i++) typed_line[i] = 8'd0;
    line_len    = 0;
    wrong_count = 0;
    pin_word    = 64'h3131_3131;
    pin_len     = 4;
    fail_limit  = 5;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_pin_directed();
    test_pin_settings();
    test_pin_grant();
    test_gate_shell_directed();
    test_gate_shell_random();

    // Drain, then give stray words time to show up.
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
